// ----- hw/rtl/i2c_ebm_pkg.sv -----
package i2c_ebm_pkg;

	// Command codes carried with each transfer
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Configuration register indexes
	localparam logic [0:0] CFG_DEVICE_ADDRESS = 1'd0;
	localparam logic [0:0] CFG_ACK_TIMEOUT    = 1'd1;

	localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd80;
	localparam logic [7:0] ACK_TIMEOUT_RST    = 8'd250;

	// Line phases, one per tick
	typedef enum logic [4:0] {
		PH_IDLE       = 5'd0,
		PH_ST_SDA1    = 5'd1,
		PH_ST_SCL1    = 5'd2,
		PH_ST_SDA0    = 5'd3,
		PH_W_SCL0     = 5'd4,
		PH_W_SDA      = 5'd5,
		PH_W_SCL1     = 5'd6,
		PH_W_END_SCL0 = 5'd7,
		PH_W_END_SDA1 = 5'd8,
		PH_ACK_SCL1   = 5'd9,
		PH_ACK_WAIT   = 5'd10,
		PH_R_SCL0     = 5'd11,
		PH_R_SDA1     = 5'd12,
		PH_R_SCL1     = 5'd13,
		PH_R_SAMPLE   = 5'd14,
		PH_N_SCL1     = 5'd15,
		PH_N_SCL0     = 5'd16,
		PH_P_SDA0     = 5'd17,
		PH_P_SCL1     = 5'd18,
		PH_P_SDA1     = 5'd19
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] bit_count;
		logic [7:0] shift_reg;
		logic [2:0] byte_step;
		logic [7:0] ack_wait;
		logic [7:0] address_latch;
		logic [7:0] data_latch;
		logic       is_read;
		logic [7:0] captured_byte;
		logic       scl_drive;
		logic       sda_drive;
	} bus_state_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] mem_address;
		logic [7:0] write_data;
		logic       sda_in;
	} tick_in_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte_out;
	} tick_out_t;

	typedef struct packed {
		logic [6:0] device_address;
		logic [7:0] ack_timeout;
	} cfg_t;

	localparam bus_state_t BUS_STATE_RST = '{
		phase:         PH_IDLE,
		bit_count:     3'd0,
		shift_reg:     8'd0,
		byte_step:     3'd0,
		ack_wait:      8'd0,
		address_latch: 8'd0,
		data_latch:    8'd0,
		is_read:       1'b0,
		captured_byte: 8'd0,
		scl_drive:     1'b1,
		sda_drive:     1'b1
	};

endpackage

// ----- hw/rtl/i2c_ebm_step.sv -----
module i2c_ebm_step (
	input  i2c_ebm_pkg::bus_state_t cur,
	input  i2c_ebm_pkg::tick_in_t   tick,
	input  i2c_ebm_pkg::cfg_t       cfg,
	output i2c_ebm_pkg::bus_state_t nxt,
	output i2c_ebm_pkg::tick_out_t  res
);
	import i2c_ebm_pkg::*;

	logic       done;
	logic [2:0] step_inc;
	logic [7:0] dev_byte;
	logic [7:0] sample_byte;

	assign step_inc    = cur.byte_step + 3'd1;
	assign dev_byte    = {cfg.device_address, 1'b0};
	assign sample_byte = {cur.shift_reg[6:0], tick.sda_in};

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		unique case (cur.phase)
			PH_IDLE: begin
				nxt.scl_drive = 1'b1;
				nxt.sda_drive = 1'b1;
				if (tick.command == CMD_WRITE || tick.command == CMD_READ) begin
					nxt.address_latch = tick.mem_address;
					nxt.data_latch    = tick.write_data;
					nxt.is_read       = (tick.command == CMD_READ);
					nxt.byte_step     = 3'd0;
					nxt.bit_count     = 3'd0;
					nxt.ack_wait      = 8'd0;
					nxt.phase         = PH_ST_SDA1;
				end
			end
			PH_ST_SDA1: begin
				nxt.sda_drive = 1'b1;
				nxt.phase     = PH_ST_SCL1;
			end
			PH_ST_SCL1: begin
				nxt.scl_drive = 1'b1;
				nxt.phase     = PH_ST_SDA0;
			end
			PH_ST_SDA0: begin
				// device byte; R/W bit set on the repeated START
				nxt.sda_drive = 1'b0;
				nxt.shift_reg = dev_byte | {7'd0, cur.byte_step != 3'd0};
				nxt.bit_count = 3'd0;
				nxt.phase     = PH_W_SCL0;
			end
			PH_W_SCL0: begin
				nxt.scl_drive = 1'b0;
				nxt.phase     = PH_W_SDA;
			end
			PH_W_SDA: begin
				nxt.sda_drive = cur.shift_reg[7];
				nxt.phase     = PH_W_SCL1;
			end
			PH_W_SCL1: begin
				nxt.scl_drive = 1'b1;
				if (cur.bit_count == 3'd7) begin
					nxt.phase = PH_W_END_SCL0;
				end else begin
					nxt.shift_reg = {cur.shift_reg[6:0], 1'b0};
					nxt.bit_count = cur.bit_count + 3'd1;
					nxt.phase     = PH_W_SCL0;
				end
			end
			PH_W_END_SCL0: begin
				nxt.scl_drive = 1'b0;
				nxt.phase     = PH_W_END_SDA1;
			end
			PH_W_END_SDA1: begin
				nxt.sda_drive = 1'b1;
				nxt.phase     = PH_ACK_SCL1;
			end
			PH_ACK_SCL1: begin
				nxt.scl_drive = 1'b1;
				nxt.ack_wait  = 8'd0;
				nxt.phase     = PH_ACK_WAIT;
			end
			PH_ACK_WAIT: begin
				if (tick.sda_in && cur.ack_wait < cfg.ack_timeout) begin
					nxt.ack_wait = cur.ack_wait + 8'd1;
				end else begin
					nxt.scl_drive = 1'b0;
					nxt.byte_step = step_inc;
					if (step_inc == 3'd1) begin
						nxt.shift_reg = cur.address_latch;
						nxt.bit_count = 3'd0;
						nxt.phase     = PH_W_SCL0;
					end else if (!cur.is_read) begin
						if (step_inc == 3'd2) begin
							nxt.shift_reg = cur.data_latch;
							nxt.bit_count = 3'd0;
							nxt.phase     = PH_W_SCL0;
						end else begin
							nxt.phase = PH_P_SDA0;
						end
					end else if (step_inc == 3'd2) begin
						nxt.phase = PH_ST_SDA1;
					end else begin
						nxt.phase = PH_R_SCL0;
					end
				end
			end
			PH_R_SCL0: begin
				nxt.scl_drive = 1'b0;
				nxt.phase     = PH_R_SDA1;
			end
			PH_R_SDA1: begin
				nxt.sda_drive = 1'b1;
				nxt.bit_count = 3'd0;
				nxt.phase     = PH_R_SCL1;
			end
			PH_R_SCL1: begin
				nxt.scl_drive = 1'b1;
				nxt.phase     = PH_R_SAMPLE;
			end
			PH_R_SAMPLE: begin
				nxt.shift_reg = sample_byte;
				nxt.scl_drive = 1'b0;
				if (cur.bit_count == 3'd7) begin
					nxt.captured_byte = sample_byte;
					nxt.phase         = PH_N_SCL1;
				end else begin
					nxt.bit_count = cur.bit_count + 3'd1;
					nxt.phase     = PH_R_SCL1;
				end
			end
			PH_N_SCL1: begin
				nxt.scl_drive = 1'b1;
				nxt.phase     = PH_N_SCL0;
			end
			PH_N_SCL0: begin
				nxt.scl_drive = 1'b0;
				nxt.phase     = PH_P_SDA0;
			end
			PH_P_SDA0: begin
				nxt.sda_drive = 1'b0;
				nxt.phase     = PH_P_SCL1;
			end
			PH_P_SCL1: begin
				nxt.scl_drive = 1'b1;
				nxt.phase     = PH_P_SDA1;
			end
			PH_P_SDA1: begin
				nxt.sda_drive = 1'b1;
				done          = 1'b1;
				nxt.phase     = PH_IDLE;
			end
			default: begin
				nxt.scl_drive = 1'b1;
				nxt.sda_drive = 1'b1;
				nxt.phase     = PH_IDLE;
			end
		endcase
	end

	assign res.scl_level     = nxt.scl_drive;
	assign res.sda_level     = nxt.sda_drive;
	assign res.busy_res      = (nxt.phase != PH_IDLE);
	assign res.done_res      = done;
	assign res.read_byte_out = nxt.captured_byte;

endmodule

// ----- hw/rtl/i2c_eeprom_byte_master_top.sv -----
// Tick-driven I2C master for a serial EEPROM (random byte write / random byte read).
// Every input transfer is one bus tick and yields exactly one result transfer carrying
// the SCL/SDA drive levels, busy, done and the last byte read. A command (write or
// read) is honored only on a tick taken while idle; mem_address and write_data are
// latched with it. ACKs are waited for up to ack_timeout ticks and never flagged.
// Throughput is one tick per clock while out_ready keeps results moving; each tick
// passes through the input register and then the result register, with the bus
// state update between them. The next tick is taken while a finished result still
// waits on out_ready; only a full input register plus a stalled result stops input.
// device_address and ack_timeout are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
module i2c_eeprom_byte_master_top (
	input  logic       clk,
	input  logic       arst_n,
	// tick channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [7:0] mem_address,
	input  logic [7:0] write_data,
	input  logic       sda_in,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl_level,
	output logic       sda_level,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_byte_out,
	// configuration writes
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import i2c_ebm_pkg::*;

	// config registers
	cfg_t cfg_q;

	// input stage
	logic     valid_s1;
	tick_in_t tick_s1;

	// bus state, updated once per tick as it moves into the result stage
	bus_state_t state_q;
	bus_state_t state_nxt;
	tick_out_t  res_nxt;

	// result stage
	logic      valid_s2;
	tick_out_t res_s2;

	logic step_en;

	assign step_en  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= DEVICE_ADDRESS_RST;
			cfg_q.ack_timeout    <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_data[6:0];
				CFG_ACK_TIMEOUT:    cfg_q.ack_timeout    <= cfg_data;
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tick_s1.command     <= command;
			tick_s1.mem_address <= mem_address;
			tick_s1.write_data  <= write_data;
			tick_s1.sda_in      <= sda_in;
		end
	end

	i2c_ebm_step u_step (
		.cur  (state_q),
		.tick (tick_s1),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BUS_STATE_RST;
		end else if (step_en) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step_en) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign scl_level     = res_s2.scl_level;
	assign sda_level     = res_s2.sda_level;
	assign busy_res      = res_s2.busy_res;
	assign done_res      = res_s2.done_res;
	assign read_byte_out = res_s2.read_byte_out;

	// STOP completion always lands back in idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && done_res |-> !busy_res)
		else $error("done reported while still busy");

	// input only blocks when both stages are full and the result is stalled
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input blocked without a stalled result");

	// bus state moves only with a tick
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(state_q))
		else $error("bus state changed without a tick");

	// idle leaves both lines released
	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_IDLE |-> state_q.scl_drive && state_q.sda_drive)
		else $error("line driven low while idle");

endmodule
